[hw/rtl/vertex_transform_4x4_macros.svh]
// Assertion macros shared by the vertex transform RTL.
`ifndef VERTEX_TRANSFORM_4X4_MACROS_SVH
`define VERTEX_TRANSFORM_4X4_MACROS_SVH

`ifndef ASSERT_OFF

// Check that a condition holds at every clock edge outside reset.
`define VT4_ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("vertex_transform_4x4: invariant violated");

// Check that a consequent holds in the same cycle as its antecedent.
`define VT4_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vertex_transform_4x4: implication violated");

// Check that a consequent holds in the cycle after its antecedent.
`define VT4_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vertex_transform_4x4: sequence violated");

`else

`define VT4_ASSERT_ALWAYS(label, clk, rst, prop)
`define VT4_ASSERT_IMPL(label, clk, rst, ante, cons)
`define VT4_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[hw/rtl/vt4_pkg.sv]
// Types and constants of the vertex transform block.
package vt4_pkg;

   localparam int COMP_WIDTH      = 16;
   localparam int COEFF_WIDTH     = 16;
   localparam int ROW_WIDTH       = 64;
   localparam int COLUMNS         = 4;
   localparam int ROWS            = 4;
   localparam int PROD_WIDTH      = 32;
   localparam int PAIR_WIDTH      = 33;
   localparam int SUM_WIDTH       = 35;
   localparam int OUT_WIDTH       = 24;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int PIPE_STAGES     = 4;

   typedef logic signed [COMP_WIDTH-1:0]   comp_type;
   typedef logic [COLUMNS-1:0][COMP_WIDTH-1:0] vertex_type;
   typedef logic [ROW_WIDTH-1:0]           row_type;
   typedef logic signed [PROD_WIDTH-1:0]   prod_type;
   typedef logic signed [PAIR_WIDTH-1:0]   pair_type;
   typedef logic signed [SUM_WIDTH-1:0]    sum_type;
   typedef logic signed [OUT_WIDTH-1:0]    out_type;
   typedef logic [CSR_INDEX_WIDTH-1:0]     csr_index_type;

   // Register indexes of the configuration port.
   localparam csr_index_type CSR_ROW_0 = 8'd0;
   localparam csr_index_type CSR_ROW_1 = 8'd1;
   localparam csr_index_type CSR_ROW_2 = 8'd2;
   localparam csr_index_type CSR_ROW_3 = 8'd3;

   // Identity matrix, 1.0 in Q8.8 on the diagonal.
   localparam row_type ROW_0_RESET = 64'h0000_0000_0000_0100;
   localparam row_type ROW_1_RESET = 64'h0000_0000_0100_0000;
   localparam row_type ROW_2_RESET = 64'h0000_0100_0000_0000;
   localparam row_type ROW_3_RESET = 64'h0100_0000_0000_0000;

   // Saturation bounds, held at sum width for direct comparison.
   localparam sum_type OUT_MAX = 35'sd8388607;
   localparam sum_type OUT_MIN = -35'sd8388608;

   // Stage load strobes from the handshake logic to each row pipeline.
   typedef struct packed {
      logic [PIPE_STAGES-1:0] load;
   } pipe_ctrl_type;

endpackage

[hw/rtl/vt4_if.sv]
// Valid/ready channel interfaces of the vertex transform block.
interface vt4_req_if;
   logic              valid;
   logic              ready;
   vt4_pkg::comp_type x_in;
   vt4_pkg::comp_type y_in;
   vt4_pkg::comp_type z_in;
   vt4_pkg::comp_type w_in;

   modport source (output valid, output x_in, output y_in, output z_in, output w_in,
                   input ready);
   modport sink   (input valid, input x_in, input y_in, input z_in, input w_in,
                   output ready);
endinterface

interface vt4_rsp_if;
   logic             valid;
   logic             ready;
   vt4_pkg::out_type x_out;
   vt4_pkg::out_type y_out;
   vt4_pkg::out_type z_out;
   vt4_pkg::out_type w_out;
   logic             saturated;

   modport source (output valid, output x_out, output y_out, output z_out,
                   output w_out, output saturated, input ready);
   modport sink   (input valid, input x_out, input y_out, input z_out,
                   input w_out, input saturated, output ready);
endinterface

interface vt4_csr_if;
   logic                   valid;
   logic                   ready;
   vt4_pkg::csr_index_type index;
   vt4_pkg::row_type       data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/vt4_row_pipe.sv]
// One matrix row: four products, adder tree, rounding and saturation.
module vt4_row_pipe #(
   parameter int COEFF_FRAC_BITS = 8
) (
   input  logic                   clock,
   input  vt4_pkg::pipe_ctrl_type ctrl,
   input  vt4_pkg::row_type       coeff,
   input  vt4_pkg::vertex_type    vertex,
   output vt4_pkg::out_type       result,
   output logic                   clamped
);

   localparam vt4_pkg::sum_type RoundOne = 1;
   // Half an output LSB; zero when there are no fraction bits.
   localparam vt4_pkg::sum_type RoundHalf = (RoundOne << COEFF_FRAC_BITS) >>> 1;

   vt4_pkg::prod_type prod_in  [vt4_pkg::COLUMNS];
   vt4_pkg::prod_type prod_ff  [vt4_pkg::COLUMNS];
   vt4_pkg::pair_type pair_in  [2];
   vt4_pkg::pair_type pair_ff  [2];
   vt4_pkg::sum_type  sum_in;
   vt4_pkg::sum_type  sum_ff;
   vt4_pkg::sum_type  shifted;
   vt4_pkg::out_type  result_in;
   vt4_pkg::out_type  result_ff;
   logic              clamped_in;
   logic              clamped_ff;

   always_comb begin
      for (int c = 0; c < vt4_pkg::COLUMNS; c++) begin
         prod_in[c] = $signed(coeff[c*vt4_pkg::COEFF_WIDTH +: vt4_pkg::COEFF_WIDTH])
                    * $signed(vertex[c]);
      end
      pair_in[0] = vt4_pkg::PAIR_WIDTH'(prod_ff[0]) + vt4_pkg::PAIR_WIDTH'(prod_ff[1]);
      pair_in[1] = vt4_pkg::PAIR_WIDTH'(prod_ff[2]) + vt4_pkg::PAIR_WIDTH'(prod_ff[3]);
      sum_in     = vt4_pkg::SUM_WIDTH'(pair_ff[0]) + vt4_pkg::SUM_WIDTH'(pair_ff[1])
                 + RoundHalf;
      // Arithmetic shift floors, completing round-half-up.
      shifted    = sum_ff >>> COEFF_FRAC_BITS;
      if (shifted > vt4_pkg::OUT_MAX) begin
         result_in  = vt4_pkg::OUT_MAX[vt4_pkg::OUT_WIDTH-1:0];
         clamped_in = 1'b1;
      end else if (shifted < vt4_pkg::OUT_MIN) begin
         result_in  = vt4_pkg::OUT_MIN[vt4_pkg::OUT_WIDTH-1:0];
         clamped_in = 1'b1;
      end else begin
         result_in  = shifted[vt4_pkg::OUT_WIDTH-1:0];
         clamped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         prod_ff <= prod_in;
      end
      if (ctrl.load[1]) begin
         pair_ff <= pair_in;
      end
      if (ctrl.load[2]) begin
         sum_ff <= sum_in;
      end
      if (ctrl.load[3]) begin
         result_ff  <= result_in;
         clamped_ff <= clamped_in;
      end
   end

   assign result  = result_ff;
   assign clamped = clamped_ff;

endmodule

[hw/rtl/vertex_transform_4x4.sv]
// Vertex transform top level: 4x4 fixed-point matrix times a stream of vertices.
// Pipeline: an accepted item reaches rsp_ch.valid through the four-stage
// multiply / add / add-round / shift-saturate pipeline in each row unit.
// Throughput: one item per clock; a stalled output backs the pipeline up stage by stage.
// Reset: synchronous, active high; clears all stage valid bits and loads the identity.
`include "vertex_transform_4x4_macros.svh"

module vertex_transform_4x4 #(
   parameter int COEFF_FRAC_BITS = 8
) (
   input logic clock,
   input logic reset,
   vt4_req_if.sink   req_ch,
   vt4_rsp_if.source rsp_ch,
   vt4_csr_if.sink   csr_ch
);

   localparam int Stages = vt4_pkg::PIPE_STAGES;

   vt4_pkg::row_type       row_coeff_ff [vt4_pkg::ROWS];
   vt4_pkg::row_type       row_coeff_in [vt4_pkg::ROWS];
   logic [Stages-1:0]      valid_ff;
   logic [Stages-1:0]      valid_in;
   logic [Stages-1:0]      stage_ready;
   vt4_pkg::pipe_ctrl_type ctrl;
   vt4_pkg::vertex_type    vertex;
   vt4_pkg::out_type       result  [vt4_pkg::ROWS];
   logic [vt4_pkg::ROWS-1:0] clamped;

   // ------------------------------------------------------------------
   // Configuration: one row of coefficients per register, always ready.
   // Writes to indexes beyond the last row are dropped.
   // ------------------------------------------------------------------
   assign csr_ch.ready = 1'b1;

   always_comb begin
      row_coeff_in = row_coeff_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            vt4_pkg::CSR_ROW_0: row_coeff_in[0] = csr_ch.data;
            vt4_pkg::CSR_ROW_1: row_coeff_in[1] = csr_ch.data;
            vt4_pkg::CSR_ROW_2: row_coeff_in[2] = csr_ch.data;
            vt4_pkg::CSR_ROW_3: row_coeff_in[3] = csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_coeff_ff[0] <= vt4_pkg::ROW_0_RESET;
         row_coeff_ff[1] <= vt4_pkg::ROW_1_RESET;
         row_coeff_ff[2] <= vt4_pkg::ROW_2_RESET;
         row_coeff_ff[3] <= vt4_pkg::ROW_3_RESET;
      end else begin
         row_coeff_ff <= row_coeff_in;
      end
   end

   // ------------------------------------------------------------------
   // Pipeline flow control. A stage takes a new item when it is empty or
   // its own item moves on; bubbles collapse, so under a stall items still move up
   // into empty stages ahead of them, the rest hold in place, and nothing is lost.
   // ------------------------------------------------------------------
   always_comb begin
      stage_ready[Stages-1] = !valid_ff[Stages-1] || rsp_ch.ready;
      for (int s = Stages - 2; s >= 0; s--) begin
         stage_ready[s] = !valid_ff[s] || stage_ready[s+1];
      end

      ctrl.load[0] = req_ch.valid && stage_ready[0];
      valid_in[0]  = stage_ready[0] ? req_ch.valid : valid_ff[0];
      for (int s = 1; s < Stages; s++) begin
         ctrl.load[s] = valid_ff[s-1] && stage_ready[s];
         valid_in[s]  = stage_ready[s] ? valid_ff[s-1] : valid_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ch.ready = stage_ready[0];

   // Column order of the vertex follows the coefficient packing.
   assign vertex[0] = req_ch.x_in;
   assign vertex[1] = req_ch.y_in;
   assign vertex[2] = req_ch.z_in;
   assign vertex[3] = req_ch.w_in;

   // ------------------------------------------------------------------
   // One dot-product pipeline per matrix row, all advanced together.
   // ------------------------------------------------------------------
   for (genvar r = 0; r < vt4_pkg::ROWS; r++) begin : g_row
      vt4_row_pipe #(
         .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
      ) u_row (
         .clock   (clock),
         .ctrl    (ctrl),
         .coeff   (row_coeff_ff[r]),
         .vertex  (vertex),
         .result  (result[r]),
         .clamped (clamped[r])
      );
   end

   // The last stage is the output register: present it and merge the flags.
   assign rsp_ch.valid     = valid_ff[Stages-1];
   assign rsp_ch.x_out     = result[0];
   assign rsp_ch.y_out     = result[1];
   assign rsp_ch.z_out     = result[2];
   assign rsp_ch.w_out     = result[3];
   assign rsp_ch.saturated = |clamped;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `VT4_ASSERT_NEXT(a_accept_fills_first, clock, reset, req_ch.valid && req_ch.ready, valid_ff[0])
   `VT4_ASSERT_NEXT(a_stall_holds_mid, clock, reset, valid_ff[1] && !stage_ready[1], valid_ff[1])
   `VT4_ASSERT_IMPL(a_backpressure_full, clock, reset, !req_ch.ready, &valid_ff)
   `VT4_ASSERT_IMPL(a_sat_at_bound, clock, reset, rsp_ch.valid && rsp_ch.saturated, (rsp_ch.x_out == vt4_pkg::OUT_MAX[23:0]) || (rsp_ch.x_out == vt4_pkg::OUT_MIN[23:0]) || (rsp_ch.y_out == vt4_pkg::OUT_MAX[23:0]) || (rsp_ch.y_out == vt4_pkg::OUT_MIN[23:0]) || (rsp_ch.z_out == vt4_pkg::OUT_MAX[23:0]) || (rsp_ch.z_out == vt4_pkg::OUT_MIN[23:0]) || (rsp_ch.w_out == vt4_pkg::OUT_MAX[23:0]) || (rsp_ch.w_out == vt4_pkg::OUT_MIN[23:0]))

endmodule

[dv/vertex_transform_4x4_tb.sv]
// Self-checking testbench for the 4x4 fixed-point vertex transform block.
`timescale 1ns / 1ps

module vertex_transform_4x4_tb;

   // Coefficient fraction bits: the block is built with the same value.
   localparam int FRAC_BITS = 8;
   // Cycles to let pass at the end once nothing is expected any more.
   localparam int SETTLE_CYCLES = 4 * vt4_pkg::PIPE_STAGES;
   // Hard stop for a hung handshake: far above the slowest correct run.
   localparam int CYCLE_LIMIT = 200_000;
   // Random vertices sent in each of the three traffic phases.
   localparam int PHASE_ITEMS = 310;

   localparam vt4_pkg::comp_type COMP_MAX = 16'sh7FFF;
   localparam vt4_pkg::comp_type COMP_MIN = 16'sh8000;
   localparam logic [vt4_pkg::COEFF_WIDTH-1:0] COEFF_ONE      = 16'h0100;
   localparam logic [vt4_pkg::COEFF_WIDTH-1:0] COEFF_HALF     = 16'h0080;
   localparam logic [vt4_pkg::COEFF_WIDTH-1:0] COEFF_NEG_HALF = 16'hFF80;
   localparam logic [vt4_pkg::COEFF_WIDTH-1:0] COEFF_LSB      = 16'h0001;
   localparam logic [vt4_pkg::COEFF_WIDTH-1:0] COEFF_NEG_LSB  = 16'hFFFF;
   localparam logic [vt4_pkg::COEFF_WIDTH-1:0] COEFF_MAX      = 16'h7FFF;
   localparam logic [vt4_pkg::COEFF_WIDTH-1:0] COEFF_MIN      = 16'h8000;
   localparam logic [vt4_pkg::COEFF_WIDTH-1:0] COEFF_ZERO     = 16'h0000;

   // Register indexes that address no row; writes to them must be dropped.
   localparam vt4_pkg::csr_index_type CSR_PAST_LAST = vt4_pkg::CSR_ROW_3 + 8'd1;
   localparam vt4_pkg::csr_index_type CSR_INDEX_TOP = '1;

   localparam longint SAT_HIGH = 64'sd8388607;
   localparam longint SAT_LOW  = -64'sd8388608;

   // One transformed vertex as the block should deliver it.
   typedef struct {
      vt4_pkg::out_type x_out;
      vt4_pkg::out_type y_out;
      vt4_pkg::out_type z_out;
      vt4_pkg::out_type w_out;
      logic             saturated;
   } vertex_result_type;

   logic clock;
   logic reset;

   vt4_req_if req_ch ();
   vt4_rsp_if rsp_ch ();
   vt4_csr_if csr_ch ();

   vertex_transform_4x4 #(
      .COEFF_FRAC_BITS (FRAC_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Our own copy of the matrix, one packed row per register.
   vt4_pkg::row_type matrix_rows [vt4_pkg::ROWS];
   // Transformed vertices still owed by the block, oldest first.
   vertex_result_type pending_vertices [$];

   int error_count = 0;
   int cycle_count = 0;
   // Percentage of cycles in which the sender holds back or the receiver stalls.
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;

   // -------------------------------------------------------------------------
   // Clock and watchdog
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Abort a run that has stopped moving.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Predictor: row dot vertex, round half up, drop fraction bits, clamp
   // -------------------------------------------------------------------------
   function automatic vertex_result_type transform_vertex(
      input vt4_pkg::comp_type x, input vt4_pkg::comp_type y,
      input vt4_pkg::comp_type z, input vt4_pkg::comp_type w);
      vertex_result_type res;
      longint comp [vt4_pkg::COLUMNS];
      vt4_pkg::out_type rows_out [vt4_pkg::ROWS];
      longint acc;
      longint coeff;
      comp[0] = x;
      comp[1] = y;
      comp[2] = z;
      comp[3] = w;
      res.saturated = 1'b0;
      for (int r = 0; r < vt4_pkg::ROWS; r++) begin
         acc = 0;
         for (int c = 0; c < vt4_pkg::COLUMNS; c++) begin
            coeff = $signed(matrix_rows[r][vt4_pkg::COEFF_WIDTH*c +: vt4_pkg::COEFF_WIDTH]);
            acc += coeff * comp[c];
         end
         // Add half an LSB, then an arithmetic shift floors: ties go upwards.
         if (FRAC_BITS > 0)
            acc += longint'(1) << (FRAC_BITS - 1);
         acc = acc >>> FRAC_BITS;
         if (acc > SAT_HIGH) begin
            acc = SAT_HIGH;
            res.saturated = 1'b1;
         end else if (acc < SAT_LOW) begin
            acc = SAT_LOW;
            res.saturated = 1'b1;
         end
         rows_out[r] = acc[vt4_pkg::OUT_WIDTH-1:0];
      end
      res.x_out = rows_out[0];
      res.y_out = rows_out[1];
      res.z_out = rows_out[2];
      res.w_out = rows_out[3];
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // Result checking
   // -------------------------------------------------------------------------
   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Receiver: starts not ready, then stalls at random, drawn anew at every falling edge.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready = ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Compare every accepted item with the oldest outstanding vertex.
   always @(posedge clock) begin : check_results
      vertex_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_vertices.size() == 0) begin
            report_error("result item with no vertex outstanding");
         end else begin
            want = pending_vertices.pop_front();
            if (rsp_ch.x_out !== want.x_out)
               report_error($sformatf("x_out expected %0d got %0d", want.x_out, rsp_ch.x_out));
            if (rsp_ch.y_out !== want.y_out)
               report_error($sformatf("y_out expected %0d got %0d", want.y_out, rsp_ch.y_out));
            if (rsp_ch.z_out !== want.z_out)
               report_error($sformatf("z_out expected %0d got %0d", want.z_out, rsp_ch.z_out));
            if (rsp_ch.w_out !== want.w_out)
               report_error($sformatf("w_out expected %0d got %0d", want.w_out, rsp_ch.w_out));
            if (rsp_ch.saturated !== want.saturated)
               report_error($sformatf("saturated expected %0b got %0b",
                                      want.saturated, rsp_ch.saturated));
         end
      end
   end

   // -------------------------------------------------------------------------
   // Drivers: every task is entered and left just after a falling edge
   // -------------------------------------------------------------------------

   // Send one vertex; record its expected result on acceptance.
   task automatic send_vertex(input vt4_pkg::comp_type x, input vt4_pkg::comp_type y,
                              input vt4_pkg::comp_type z, input vt4_pkg::comp_type w);
      // Hold back at random, with junk on x_in and w_in of the idle bus.
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.x_in = $urandom;
         req_ch.w_in = $urandom;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.x_in  = x;
      req_ch.y_in  = y;
      req_ch.z_in  = z;
      req_ch.w_in  = w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_vertices.push_back(transform_vertex(x, y, z, w));
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   // Write one register and mirror it in the predictor's matrix.
   task automatic write_row(input vt4_pkg::csr_index_type idx,
                            input vt4_pkg::row_type value);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      // Indexes past the last row are dropped by the block.
      if (idx < vt4_pkg::ROWS)
         matrix_rows[idx] = value;
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic load_matrix(input vt4_pkg::row_type r0, input vt4_pkg::row_type r1,
                              input vt4_pkg::row_type r2, input vt4_pkg::row_type r3);
      write_row(vt4_pkg::CSR_ROW_0, r0);
      write_row(vt4_pkg::CSR_ROW_1, r1);
      write_row(vt4_pkg::CSR_ROW_2, r2);
      write_row(vt4_pkg::CSR_ROW_3, r3);
   endtask

   // Hold until every outstanding vertex has come back.
   task automatic wait_drain();
      while (pending_vertices.size() != 0) @(negedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Random content
   // -------------------------------------------------------------------------
   function automatic vt4_pkg::comp_type random_comp();
      case ($urandom_range(7))
         0:       return COMP_MAX;
         1:       return COMP_MIN;
         2:       return vt4_pkg::comp_type'($urandom_range(512) - 256);
         default: return vt4_pkg::comp_type'($urandom);
      endcase
   endfunction

   function automatic logic [vt4_pkg::COEFF_WIDTH-1:0] random_coeff();
      case ($urandom_range(7))
         0:       return COEFF_MAX;
         1:       return COEFF_MIN;
         2:       return COEFF_ZERO;
         3:       return ($urandom_range(1)) ? COEFF_ONE : -COEFF_ONE;
         4:       return vt4_pkg::COEFF_WIDTH'($urandom_range(1024) - 512);
         default: return vt4_pkg::COEFF_WIDTH'($urandom);
      endcase
   endfunction

   function automatic vt4_pkg::row_type random_row();
      return {random_coeff(), random_coeff(), random_coeff(), random_coeff()};
   endfunction

   // Pick a new matrix: mostly random rows, now and then a uniform extreme.
   task automatic load_random_matrix();
      vt4_pkg::row_type fill;
      case ($urandom_range(7))
         0:       fill = {4{COEFF_ZERO}};
         1:       fill = {4{COEFF_MAX}};
         2:       fill = {4{COEFF_MIN}};
         3:       fill = {4{COEFF_NEG_LSB}};
         default: fill = '0;
      endcase
      if (fill != '0 || $urandom_range(7) == 0)
         load_matrix(fill, fill, fill, fill);
      else
         load_matrix(random_row(), random_row(), random_row(), random_row());
      // Now and then aim a write at an index with no row behind it.
      if ($urandom_range(3) == 0)
         write_row(vt4_pkg::csr_index_type'($urandom_range(CSR_PAST_LAST, CSR_INDEX_TOP)),
                   {$urandom, $urandom});
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Identity matrix out of reset: every component must pass through unchanged.
   task automatic test_reset_identity();
      send_vertex(COMP_MAX, COMP_MIN, 16'sd0, 16'sd1);
      send_vertex(COMP_MIN, COMP_MAX, -16'sd1, 16'sd0);
      send_vertex(16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_vertex(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX);
      send_vertex(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN);
   endtask

   // Half and single-LSB coefficients: ties must round towards plus infinity.
   task automatic test_rounding();
      wait_drain();
      load_matrix({COEFF_ZERO, COEFF_ZERO, COEFF_ZERO, COEFF_HALF},
                  {COEFF_ZERO, COEFF_ZERO, COEFF_NEG_HALF, COEFF_ZERO},
                  {COEFF_ZERO, COEFF_LSB, COEFF_ZERO, COEFF_ZERO},
                  {COEFF_NEG_LSB, COEFF_ZERO, COEFF_ZERO, COEFF_ZERO});
      send_vertex(16'sd1, 16'sd1, 16'sd1, 16'sd1);
      send_vertex(16'sd3, 16'sd3, 16'sd3, 16'sd3);
      send_vertex(-16'sd1, -16'sd1, 16'sd128, -16'sd128);
      send_vertex(-16'sd3, 16'sd5, -16'sd128, 16'sd128);
      send_vertex(COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN);
   endtask

   // Out of range sums: clamp high and low.
   task automatic test_saturation();
      wait_drain();
      load_matrix({4{COEFF_MAX}},
                  {4{COEFF_MIN}},
                  {COEFF_MIN, COEFF_MAX, COEFF_MIN, COEFF_MAX},
                  {COEFF_ZERO, COEFF_ZERO, COEFF_MIN, COEFF_MIN});
      send_vertex(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX);
      send_vertex(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN);
      send_vertex(COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN);
      send_vertex(COMP_MIN, -16'sd32767, 16'sd0, 16'sd0);
      send_vertex(16'sd1, 16'sd1, 16'sd1, 16'sd1);
      send_vertex(16'sd0, 16'sd0, 16'sd0, 16'sd0);
   endtask

   // Writes to indexes beyond the last row must leave the matrix alone.
   task automatic test_ignored_index();
      wait_drain();
      write_row(CSR_PAST_LAST, '1);
      write_row(CSR_INDEX_TOP, {$urandom, $urandom});
      send_vertex(COMP_MAX, COMP_MIN, 16'sd1, -16'sd1);
      send_vertex(16'sd100, -16'sd100, 16'sd7, -16'sd7);
   endtask

   // Bursts of random vertices, each burst under a freshly loaded matrix.
   task automatic test_random_traffic(input int item_count);
      int sent;
      int burst;
      int pause_at;
      sent = 0;
      while (sent < item_count) begin
         wait_drain();
         load_random_matrix();
         burst    = $urandom_range(10, 60);
         pause_at = $urandom_range(burst - 1);
         for (int i = 0; i < burst && sent < item_count; i++) begin
            send_vertex(random_comp(), random_comp(), random_comp(), random_comp());
            sent++;
            // Starve the block once per burst so the pipeline runs fully empty.
            if (i == pause_at)
               wait_drain();
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      // Identity matrix, as the block comes out of reset.
      for (int r = 0; r < vt4_pkg::ROWS; r++)
         matrix_rows[r] = vt4_pkg::row_type'(COEFF_ONE) << (vt4_pkg::COEFF_WIDTH * r);

      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.x_in  = '0;
      req_ch.y_in  = '0;
      req_ch.z_in  = '0;
      req_ch.w_in  = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data  = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Phase one: sender idles lightly, receiver stalls heavily.
      req_idle_pct  = 26;
      rsp_stall_pct = 60;
      test_reset_identity();
      test_rounding();
      test_saturation();
      test_ignored_index();
      test_random_traffic(PHASE_ITEMS);

      // Phase two: the other way round.
      req_idle_pct  = 60;
      rsp_stall_pct = 26;
      test_random_traffic(PHASE_ITEMS);

      // Phase three: full rate on both sides.
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      test_random_traffic(PHASE_ITEMS);

      // Drain, then give any stray result time to show up.
      wait_drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
